/* src/ngs_pkg.sv */
// shared types and constants for the next greater element stack unit
`default_nettype none
package ngs_pkg;

    // width of one array element
    localparam int unsigned DATA_W = 32;

    // answer reported when no greater element exists
    localparam logic [DATA_W-1:0] NOT_FOUND = '1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD
    } ngs_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic pop;
        logic load_top;
        logic finish;
    } ngs_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic top_le;
        logic out_hold;
    } ngs_stat_t;

endpackage
`default_nettype wire

/* src/ngs_ram.sv */
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module ngs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* src/ngs_ctrl.sv */
// controller state machine: accept, pop loop, report and push
`default_nettype none
module ngs_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire ngs_pkg::ngs_stat_t stat,
    output ngs_pkg::ngs_cmd_t      cmd
);
    import ngs_pkg::*;

    ngs_state_t state_reg;
    ngs_state_t state_next;
    logic       do_pop;

    // pop while the top candidate is not greater than the value
    assign do_pop = !stat.empty && stat.top_le;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (do_pop) begin
                    state_next = ST_LOAD;
                end else if (!stat.out_hold) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD: begin
                state_next = ST_CHECK;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_CHECK: begin
                cmd.pop    = do_pop;
                cmd.finish = !do_pop && !stat.out_hold;
            end
            ST_LOAD: begin
                cmd.load_top = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/ngs_datapath.sv */
// datapath: candidate stack in ram, cached top, count and result register
`default_nettype none
module ngs_datapath #(
    parameter int unsigned STACK_DEPTH = 128
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire ngs_pkg::ngs_cmd_t           cmd,
    output ngs_pkg::ngs_stat_t               stat,
    input  wire logic [ngs_pkg::DATA_W-1:0]  s_tdata,
    input  wire logic                        s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [ngs_pkg::DATA_W-1:0]  m_tdata,
    output logic      [1:0]                  m_tuser
);
    import ngs_pkg::*;

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = $clog2(STACK_DEPTH);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] top_reg;
    logic [DATA_W-1:0] top_next;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [DATA_W-1:0] m_tdata_reg;
    logic [1:0]        m_tuser_reg;
    logic              full;
    logic              empty;
    logic              push;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CW'(STACK_DEPTH));
    assign push  = cmd.finish && !full;

    // status toward the controller
    assign stat.empty    = empty;
    assign stat.top_le   = ($signed(top_reg) <= $signed(value_reg));
    assign stat.out_hold = m_tvalid_reg && !m_tready;

    // after a pop the new top sits one below the new count
    assign rd_addr = AW'(cnt_reg - CW'(2));

    // candidate stack storage
    ngs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (push),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (value_reg),
        .re    (cmd.pop),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // count and cached top
    always_comb begin
        cnt_next = cnt_reg;
        top_next = top_reg;
        if (cmd.accept && s_tuser) begin
            cnt_next = '0;
        end
        if (cmd.pop) begin
            cnt_next = cnt_reg - CW'(1);
        end
        if (cmd.load_top) begin
            top_next = rd_data;
        end
        if (push) begin
            cnt_next = cnt_reg + CW'(1);
            top_next = value_reg;
        end
    end

    // result beat valid
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.finish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (cmd.accept) begin
            value_reg <= s_tdata;
        end
        if (cmd.finish) begin
            m_tdata_reg <= empty ? NOT_FOUND : top_reg;
            m_tuser_reg <= {full, !empty};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !(m_tvalid_reg && !m_tready))
        else $error("result overwritten while held");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> !empty)
        else $error("pop from empty stack");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> cnt_reg == CW'($past(cnt_reg) + CW'(1)))
        else $error("push did not advance count");

    a_pop_then_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |=> cmd.load_top)
        else $error("pop not followed by top load");
`endif

endmodule
`default_nettype wire

/* src/next_greater_element_stack_unit.sv */
// top level of the next greater element stack unit
// Takes signed 32-bit array elements fed from the last element to the first
// and returns, per element, the nearest strictly greater element to its
// right (or -1 with found low). A beat with s_tuser high empties the stack
// before it is processed; reset leaves the stack empty too. When STACK_DEPTH
// candidates remain after popping, the value is not pushed and overflow is
// set. An element is accepted in the idle state, then compared and reported
// in the check state, which waits while a held result is not taken; each
// candidate it pops adds a pop and a load of the new top, since each pop waits
// on one registered read of the stack ram for the new top. Each element is
// popped at most once. One finished result may wait in the output register
// while the next beat is taken in. No clearing pass is needed after reset.
`default_nettype none
module next_greater_element_stack_unit #(
    parameter int unsigned STACK_DEPTH = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value
    input  wire logic        s_tuser,   // start_req
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // next_greater
    output logic      [1:0]  m_tuser    // found, overflow
);
    import ngs_pkg::*;

    ngs_cmd_t  cmd;
    ngs_stat_t stat;

    // sequencing of accept, pop loop and report
    ngs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stack, compare and result register
    ngs_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

/* tb/tb_next_greater_element_stack_unit.sv */
// self-checking testbench for the next greater element stack unit
`timescale 1ns / 1ps

module tb_next_greater_element_stack_unit;
    import ngs_pkg::*;

    localparam int unsigned DEPTH      = 128;
    localparam int          ITEM_GOAL  = 1250;
    localparam int          CYCLE_CAP  = 200000;
    localparam int          HOLD_AT    = 300;
    localparam int          HOLD_LEN   = 250;
    localparam int          CALM_FROM  = 700;
    localparam int          CALM_TO    = 850;
    localparam int          DRAIN      = 12;

    // one expected answer
    typedef struct {
        logic [DATA_W-1:0] next_greater;
        logic              found;
        logic              overflow;
    } answer_t;

    // tracks the candidate stack and checks answers in order
    class next_greater_predictor;
        logic signed [DATA_W-1:0] cand [DEPTH];
        int unsigned              cand_count;
        answer_t                  pending_answers [$];
        int                       errors;
        int                       checked;
        int                       n_found;
        int                       n_overflow;
        int                       n_start;

        function new();
            cand_count = 0;
            errors     = 0;
            checked    = 0;
            n_found    = 0;
            n_overflow = 0;
            n_start    = 0;
        endfunction

        // accepted input beat: pop, report top, push
        function void record_element(input logic signed [DATA_W-1:0] value,
                                     input logic start);
            answer_t ans;
            if (start) begin
                cand_count = 0;
                n_start++;
            end
            // equal values pop as well
            while (cand_count > 0 && cand[cand_count-1] <= value)
                cand_count--;
            if (cand_count == 0) begin
                ans.next_greater = NOT_FOUND;
                ans.found        = 1'b0;
            end else begin
                ans.next_greater = cand[cand_count-1];
                ans.found        = 1'b1;
                n_found++;
            end
            // full stack drops the value
            if (cand_count < DEPTH) begin
                cand[cand_count] = value;
                cand_count++;
                ans.overflow = 1'b0;
            end else begin
                ans.overflow = 1'b1;
                n_overflow++;
            end
            pending_answers.push_back(ans);
        endfunction

        // accepted result beat against the oldest expectation
        function void check_answer(input logic [DATA_W-1:0] data, input logic [1:0] user);
            answer_t ans;
            if (pending_answers.size() == 0) begin
                $error("unexpected result beat: next_greater %h user %b", data, user);
                errors++;
                return;
            end
            ans = pending_answers.pop_front();
            checked++;
            if (data !== ans.next_greater) begin
                $error("next_greater: expected %h, got %h", ans.next_greater, data);
                errors++;
            end
            if (user[0] !== ans.found) begin
                $error("found: expected %b, got %b", ans.found, user[0]);
                errors++;
            end
            if (user[1] !== ans.overflow) begin
                $error("overflow: expected %b, got %b", ans.overflow, user[1]);
                errors++;
            end
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;    // value
    logic              s_tuser;    // start_req
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;    // next_greater
    logic [1:0]        m_tuser;    // found, overflow

    next_greater_predictor sb = new();

    int  sent_items = 0;
    int  arrays     = 0;
    int  cycles     = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    bit  calm       = 1'b0;

    next_greater_element_stack_unit #(
        .STACK_DEPTH (DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: check beats, random stalls, one long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_answer(m_tdata, m_tuser);
        if (!hold_done && sent_items >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(99) < 14) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // optional random gap before a beat
    task automatic idle_gap();
        calm = (sent_items >= CALM_FROM && sent_items < CALM_TO);
        if (!calm && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    // offer one element and wait for it to be taken
    task automatic send_beat(input logic [31:0] value, input logic start);
        idle_gap();
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.record_element(value, start);
        sent_items++;
    endtask

    // random element, extremes now and then; spread 0 means full range
    function automatic logic [31:0] any_value(input int spread);
        int unsigned pick;
        int          off;
        pick = $urandom_range(15);
        if (pick == 0)
            return 32'h8000_0000;
        if (pick == 1)
            return 32'h7fff_ffff;
        if (spread == 0)
            return $urandom;
        off = $urandom_range(2 * spread);
        return off - spread;
    endfunction

    initial begin
        int          len;
        int          kind;
        int          i;
        logic [31:0] base;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: no start mark after reset, equal pops, extremes
        send_beat(32'd10, 1'b0);
        send_beat(32'd10, 1'b0);
        send_beat(32'd3, 1'b0);
        send_beat(32'h8000_0000, 1'b0);
        send_beat(32'h7fff_ffff, 1'b0);
        send_beat(32'hffff_ffff, 1'b0);
        send_beat(32'd0, 1'b0);
        // start mark mid-stream, equal minimum and maximum
        send_beat(32'h8000_0000, 1'b1);
        send_beat(32'h8000_0000, 1'b0);
        send_beat(32'h7fff_ffff, 1'b1);
        send_beat(32'h7fff_ffff, 1'b0);
        send_beat(32'h5555_5555, 1'b0);
        send_beat(32'haaaa_aaaa, 1'b0);
        // small negatives with partial pops
        send_beat(-32'sd5, 1'b1);
        send_beat(-32'sd6, 1'b0);
        send_beat(-32'sd7, 1'b0);
        send_beat(-32'sd5, 1'b0);
        send_beat(-32'sd6, 1'b0);
        send_beat(32'hffff_ffff, 1'b0);

        // random arrays, each led by a start mark but the noise arrays
        while (sent_items < ITEM_GOAL) begin
            kind = $urandom_range(9);
            if (arrays == 3 || arrays == 15 || arrays == 30) begin
                // strictly decreasing run past the stack depth, then a short tail
                len  = DEPTH + $urandom_range(12, 1);
                base = $urandom_range(32'h4000_0000, 32'h0000_1000);
                for (i = 0; i < len; i++) begin
                    send_beat(base, i == 0);
                    base = base - $urandom_range(3, 1);
                end
                for (i = 0; i < 3; i++)
                    send_beat(any_value(0), 1'b0);
            end else if (kind <= 3) begin
                len = $urandom_range(40, 1);
                for (i = 0; i < len; i++)
                    send_beat(any_value(0), i == 0);
            end else if (kind <= 6) begin
                // narrow values, many ties
                len = $urandom_range(40, 1);
                for (i = 0; i < len; i++)
                    send_beat(any_value(4), i == 0);
            end else if (kind == 7) begin
                // noise: start marks anywhere
                len = $urandom_range(20, 1);
                for (i = 0; i < len; i++)
                    send_beat(any_value(0), $urandom_range(5) == 0);
            end else begin
                // mostly decreasing, deep stacks with occasional bursts of pops
                len  = $urandom_range(60, 1);
                base = $urandom_range(32'h1000_0000, 32'h0000_0100);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(7) == 0)
                        send_beat(base + $urandom_range(1000), i == 0);
                    else
                        send_beat(base, i == 0);
                    base = base - $urandom_range(50);
                end
            end
            arrays++;
        end
        s_tvalid <= 1'b0;

        // drain
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("fed %0d elements in %0d arrays plus directed ones, %0d answers checked",
                 sent_items, arrays, sb.checked);
        $display("%0d answers found, %0d overflows, %0d start marks, %0d cycles",
                 sb.n_found, sb.n_overflow, sb.n_start, cycles);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
src/ngs_pkg.sv
src/ngs_ram.sv
src/ngs_ctrl.sv
src/ngs_datapath.sv
src/next_greater_element_stack_unit.sv
tb/tb_next_greater_element_stack_unit.sv
